>>> src/stt_pkg.sv
// Shared types, token codes, character constants and classification helpers
// for the source text tokenizer. No dependencies.
package stt_pkg;

   localparam int LEXEME_BYTES_DEF = 32;
   localparam int QUEUE_DEPTH_DEF  = 4;
   localparam int LEN_MAX_W        = 6;   // holds any stored length up to 63
   localparam int LIMIT_W          = 16;
   localparam logic [LIMIT_W-1:0] TOKEN_LIMIT_RESET = 16'd4096;

   // token codes
   localparam logic [5:0] TK_IDENT    = 6'd0;
   localparam logic [5:0] TK_NUMBER   = 6'd1;
   localparam logic [5:0] TK_STRING   = 6'd2;
   localparam logic [5:0] TK_KEYWORD0 = 6'd3;
   localparam logic [5:0] TK_INC      = 6'd20;
   localparam logic [5:0] TK_DEC      = 6'd21;
   localparam logic [5:0] TK_EQ_EQ    = 6'd22;
   localparam logic [5:0] TK_NOT_EQ   = 6'd23;
   localparam logic [5:0] TK_GT_EQ    = 6'd24;
   localparam logic [5:0] TK_LT_EQ    = 6'd25;
   localparam logic [5:0] TK_ADD_EQ   = 6'd26;
   localparam logic [5:0] TK_SUB_EQ   = 6'd27;
   localparam logic [5:0] TK_MUL_EQ   = 6'd28;
   localparam logic [5:0] TK_DIV_EQ   = 6'd29;
   localparam logic [5:0] TK_LBRACE   = 6'd30;
   localparam logic [5:0] TK_RBRACE   = 6'd31;
   localparam logic [5:0] TK_LPAREN   = 6'd32;
   localparam logic [5:0] TK_RPAREN   = 6'd33;
   localparam logic [5:0] TK_LBRACK   = 6'd34;
   localparam logic [5:0] TK_RBRACK   = 6'd35;
   localparam logic [5:0] TK_COMMA    = 6'd36;
   localparam logic [5:0] TK_ASSIGN   = 6'd37;
   localparam logic [5:0] TK_GT       = 6'd38;
   localparam logic [5:0] TK_LT       = 6'd39;
   localparam logic [5:0] TK_PLUS     = 6'd40;
   localparam logic [5:0] TK_MINUS    = 6'd41;
   localparam logic [5:0] TK_STAR     = 6'd42;
   localparam logic [5:0] TK_SLASH    = 6'd43;
   localparam logic [5:0] TK_PERCENT  = 6'd44;
   localparam logic [5:0] TK_DOT      = 6'd45;
   localparam logic [5:0] TK_UNKNOWN  = 6'd46;
   localparam logic [5:0] TK_EOF      = 6'd47;
   localparam logic [5:0] TK_OVERFLOW = 6'd48;

   // characters
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_PCT    = 8'h25;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;

   localparam int KW_COUNT = 17;
   localparam logic [79:0] KW_TEXT [KW_COUNT] = '{
      "var", "ret", "out", "rep", "fun", "if", "else", "end", "keyPressed",
      "keyDown", "add", "stop", "str", "and", "or", "not", "qbit"};
   localparam int KW_LEN [KW_COUNT] = '{3, 3, 3, 3, 3, 2, 4, 3, 10, 7, 3, 4, 3, 3, 2, 3, 4};

   typedef enum logic [2:0] {
      M_IDLE, M_HOLD, M_IDENT, M_NUMBER, M_NUMDOT, M_FRACTION, M_STRING, M_COMMENT
   } scan_mode_type;

   typedef enum logic [2:0] {
      F_ACCEPT, F_FEED, F_APP2, F_FLUSH, F_MARK
   } front_state_type;

   typedef enum logic [1:0] {
      B_IDLE, B_READ, B_ROW
   } back_state_type;

   typedef enum logic [1:0] {
      CMD_PLAIN, CMD_TEXT, CMD_MARK
   } cmd_kind_type;

   // one queued command: a text-free token, a text token, or end of item
   typedef struct packed {
      cmd_kind_type         kind;
      logic [5:0]           tok;
      logic [LEN_MAX_W-1:0] len;
      logic                 bank;
   } cmd_type;

   typedef struct packed {
      logic [5:0] tok;
      logic [4:0] len;
      logic [4:0] pos;
      logic [7:0] ch;
      logic       tend;
   } row_type;

   typedef struct packed {
      logic q_full;
      logic drained;
   } stt_status_type;

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {[8'h30:8'h39]};
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c inside {[8'h09:8'h0D], CH_SPACE};
   endfunction

   function automatic logic is_held(input logic [7:0] c);
      return c inside {CH_PLUS, CH_MINUS, CH_EQ, CH_BANG, CH_GT, CH_LT, CH_STAR,
                       CH_SLASH, CH_DOT};
   endfunction

   function automatic logic [5:0] single_code(input logic [7:0] c);
      logic [5:0] t;
      case (c)
         CH_LBRACE: t = TK_LBRACE;
         CH_RBRACE: t = TK_RBRACE;
         CH_LPAREN: t = TK_LPAREN;
         CH_RPAREN: t = TK_RPAREN;
         CH_LBRACK: t = TK_LBRACK;
         CH_RBRACK: t = TK_RBRACK;
         CH_COMMA:  t = TK_COMMA;
         CH_EQ:     t = TK_ASSIGN;
         CH_GT:     t = TK_GT;
         CH_LT:     t = TK_LT;
         CH_PLUS:   t = TK_PLUS;
         CH_MINUS:  t = TK_MINUS;
         CH_STAR:   t = TK_STAR;
         CH_SLASH:  t = TK_SLASH;
         CH_PCT:    t = TK_PERCENT;
         CH_DOT:    t = TK_DOT;
         default:   t = TK_UNKNOWN;
      endcase
      return t;
   endfunction

   // code of "h=", or TK_UNKNOWN when h has no compound form
   function automatic logic [5:0] assign_code(input logic [7:0] h);
      logic [5:0] t;
      case (h)
         CH_EQ:    t = TK_EQ_EQ;
         CH_BANG:  t = TK_NOT_EQ;
         CH_GT:    t = TK_GT_EQ;
         CH_LT:    t = TK_LT_EQ;
         CH_PLUS:  t = TK_ADD_EQ;
         CH_MINUS: t = TK_SUB_EQ;
         CH_STAR:  t = TK_MUL_EQ;
         CH_SLASH: t = TK_DIV_EQ;
         default:  t = TK_UNKNOWN;
      endcase
      return t;
   endfunction

   function automatic logic [7:0] kw_char(input int k, input int p);
      logic [7:0] r;
      r = 8'h00;
      if (p < KW_LEN[k]) begin
         r = KW_TEXT[k][8*(KW_LEN[k]-1-p) +: 8];
      end
      return r;
   endfunction

endpackage

>>> src/stt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module stt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> src/stt_queue.sv
// Short command queue between the scanner front and the emitter back.
// Depends on stt_pkg (cmd_type).
module stt_queue import stt_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEF,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head,
   output logic    empty,
   output logic    full
);

   cmd_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign empty   = (cnt_ff == '0);
   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

>>> src/stt_front.sv
// Scanner front: accepts source bytes, runs the lexer state machine one step
// a cycle while the queue has room, writes lexeme text and queues token commands. Depends on stt_pkg.
module stt_front import stt_pkg::*; #(
   parameter int LEXEME_BYTES = LEXEME_BYTES_DEF,
   localparam int IDX_W = $clog2(LEXEME_BYTES)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_char_value,
   input  logic                req_end_of_source,
   input  logic [LIMIT_W-1:0]  token_limit,
   input  stt_status_type      status,
   output logic                push,
   output cmd_type             cmd,
   output logic                ram_we,
   output logic [IDX_W:0]      ram_waddr,
   output logic [7:0]          ram_wdata
);

   localparam logic [IDX_W-1:0] LEN_CAP = IDX_W'(LEXEME_BYTES - 1);

   front_state_type     fst_ff, fst_in;
   scan_mode_type       mode_ff, mode_in;
   logic [7:0]          held_ff, held_in;
   logic [7:0]          cur_ff, cur_in;
   logic                last_ff, last_in;
   logic [IDX_W-1:0]    len_ff, len_in;
   logic                bank_ff, bank_in;
   logic [KW_COUNT-1:0] kwm_ff, kwm_in;
   logic [LIMIT_W-1:0]  cnt_ff, cnt_in;
   logic                ovf_ff, ovf_in;

   logic                new_tok, do_app, done, res_hit, bank_n;
   logic [7:0]          app_c, c;
   logic [IDX_W-1:0]    idx;
   logic [KW_COUNT-1:0] kw_base;
   logic [5:0]          id_code;
   cmd_kind_type        text_kind;

   assign c         = cur_ff;
   assign res_hit   = ({1'b0, cnt_ff} + 17'd1) >= {1'b0, token_limit};
   assign text_kind = (len_ff == '0) ? CMD_PLAIN : CMD_TEXT;

   always_comb begin
      id_code = TK_IDENT;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         if (kwm_ff[k] && (int'(len_ff) == KW_LEN[k])) begin
            id_code = TK_KEYWORD0 + 6'(k);
         end
      end
   end

   always_comb begin
      fst_in    = fst_ff;
      mode_in   = mode_ff;
      held_in   = held_ff;
      cur_in    = cur_ff;
      last_in   = last_ff;
      len_in    = len_ff;
      bank_in   = bank_ff;
      kwm_in    = kwm_ff;
      cnt_in    = cnt_ff;
      ovf_in    = ovf_ff;
      push      = 1'b0;
      cmd.kind  = CMD_PLAIN;
      cmd.tok   = TK_UNKNOWN;
      cmd.len   = LEN_MAX_W'(len_ff);
      cmd.bank  = bank_ff;
      new_tok   = 1'b0;
      do_app    = 1'b0;
      app_c     = cur_ff;
      done      = 1'b0;
      req_stall = 1'b1;
      ram_we    = 1'b0;
      ram_waddr = '0;
      ram_wdata = app_c;
      idx       = len_ff;
      bank_n    = bank_ff;
      kw_base   = kwm_ff;

      case (fst_ff)
         F_ACCEPT: begin
            req_stall = !status.drained;
            if (req_valid && status.drained) begin
               cur_in  = req_char_value;
               last_in = req_end_of_source;
               if (ovf_ff) begin
                  // drop the byte; only the end of source still matters
                  fst_in = req_end_of_source ? F_MARK : F_ACCEPT;
               end else begin
                  fst_in = F_FEED;
               end
            end
         end
         F_FEED: begin
            if (!status.q_full) begin
               case (mode_ff)
                  M_IDLE: begin
                     done = 1'b1;
                     if (is_space(c)) begin
                        mode_in = M_IDLE;
                     end else if (is_held(c)) begin
                        held_in = c;
                        mode_in = M_HOLD;
                     end else if (res_hit) begin
                        push    = 1'b1;
                        cmd.tok = TK_OVERFLOW;
                        ovf_in  = 1'b1;
                     end else begin
                        cnt_in = cnt_ff + 16'd1;
                        if (c == CH_QUOTE) begin
                           new_tok = 1'b1;
                           mode_in = M_STRING;
                        end else if (is_digit(c)) begin
                           new_tok = 1'b1;
                           do_app  = 1'b1;
                           mode_in = M_NUMBER;
                        end else if (is_alpha(c)) begin
                           new_tok = 1'b1;
                           do_app  = 1'b1;
                           mode_in = M_IDENT;
                        end else begin
                           push    = 1'b1;
                           cmd.tok = single_code(c);
                        end
                     end
                  end
                  M_HOLD: begin
                     if (held_ff == CH_SLASH && c == CH_SLASH) begin
                        mode_in = M_COMMENT;
                        done    = 1'b1;
                     end else if (res_hit) begin
                        push    = 1'b1;
                        cmd.tok = TK_OVERFLOW;
                        ovf_in  = 1'b1;
                        mode_in = M_IDLE;
                        done    = 1'b1;
                     end else begin
                        cnt_in = cnt_ff + 16'd1;
                        if (held_ff == CH_DOT && is_digit(c)) begin
                           new_tok = 1'b1;
                           do_app  = 1'b1;
                           app_c   = CH_DOT;
                           mode_in = M_FRACTION;
                           fst_in  = F_APP2;
                        end else begin
                           mode_in = M_IDLE;
                           push    = 1'b1;
                           if (held_ff == CH_PLUS && c == CH_PLUS) begin
                              cmd.tok = TK_INC;
                              done    = 1'b1;
                           end else if (held_ff == CH_MINUS && c == CH_MINUS) begin
                              cmd.tok = TK_DEC;
                              done    = 1'b1;
                           end else if (c == CH_EQ && assign_code(held_ff) != TK_UNKNOWN) begin
                              cmd.tok = assign_code(held_ff);
                              done    = 1'b1;
                           end else begin
                              // the look-ahead byte is scanned again from idle
                              cmd.tok = single_code(held_ff);
                           end
                        end
                     end
                  end
                  M_IDENT: begin
                     if (is_alpha(c) || is_digit(c)) begin
                        do_app = 1'b1;
                        done   = 1'b1;
                     end else begin
                        push     = 1'b1;
                        cmd.kind = text_kind;
                        cmd.tok  = id_code;
                        mode_in  = M_IDLE;
                     end
                  end
                  M_NUMBER: begin
                     if (is_digit(c)) begin
                        do_app = 1'b1;
                        done   = 1'b1;
                     end else if (c == CH_DOT) begin
                        mode_in = M_NUMDOT;
                        done    = 1'b1;
                     end else begin
                        push     = 1'b1;
                        cmd.kind = text_kind;
                        cmd.tok  = TK_NUMBER;
                        mode_in  = M_IDLE;
                     end
                  end
                  M_NUMDOT: begin
                     if (is_digit(c)) begin
                        do_app  = 1'b1;
                        app_c   = CH_DOT;
                        mode_in = M_FRACTION;
                        fst_in  = F_APP2;
                     end else begin
                        push     = 1'b1;
                        cmd.kind = text_kind;
                        cmd.tok  = TK_NUMBER;
                        held_in  = CH_DOT;
                        mode_in  = M_HOLD;
                     end
                  end
                  M_FRACTION: begin
                     if (is_digit(c)) begin
                        do_app = 1'b1;
                        done   = 1'b1;
                     end else begin
                        push     = 1'b1;
                        cmd.kind = text_kind;
                        cmd.tok  = TK_NUMBER;
                        mode_in  = M_IDLE;
                     end
                  end
                  M_STRING: begin
                     done = 1'b1;
                     if (c == CH_QUOTE) begin
                        push     = 1'b1;
                        cmd.kind = text_kind;
                        cmd.tok  = TK_STRING;
                        mode_in  = M_IDLE;
                     end else begin
                        do_app = 1'b1;
                     end
                  end
                  M_COMMENT: begin
                     done = 1'b1;
                     if (c == CH_NL) begin
                        mode_in = M_IDLE;
                     end
                  end
                  default: begin
                     mode_in = M_IDLE;
                     done    = 1'b1;
                  end
               endcase
            end
         end
         F_APP2: begin
            do_app = 1'b1;
            done   = 1'b1;
         end
         F_FLUSH: begin
            if (ovf_ff) begin
               fst_in = F_MARK;
            end else if (!status.q_full) begin
               push = 1'b1;
               case (mode_ff)
                  M_IDENT: begin
                     cmd.kind = text_kind;
                     cmd.tok  = id_code;
                     mode_in  = M_IDLE;
                  end
                  M_NUMBER, M_FRACTION: begin
                     cmd.kind = text_kind;
                     cmd.tok  = TK_NUMBER;
                     mode_in  = M_IDLE;
                  end
                  M_STRING: begin
                     cmd.kind = text_kind;
                     cmd.tok  = TK_STRING;
                     mode_in  = M_IDLE;
                  end
                  M_NUMDOT: begin
                     cmd.kind = text_kind;
                     cmd.tok  = TK_NUMBER;
                     held_in  = CH_DOT;
                     mode_in  = M_HOLD;
                  end
                  M_HOLD: begin
                     mode_in = M_IDLE;
                     if (res_hit) begin
                        cmd.tok = TK_OVERFLOW;
                        ovf_in  = 1'b1;
                     end else begin
                        cnt_in  = cnt_ff + 16'd1;
                        cmd.tok = single_code(held_ff);
                     end
                  end
                  default: begin
                     cmd.tok = TK_EOF;
                     fst_in  = F_MARK;
                  end
               endcase
            end
         end
         F_MARK: begin
            if (!status.q_full) begin
               push     = 1'b1;
               cmd.kind = CMD_MARK;
               fst_in   = F_ACCEPT;
               if (last_ff) begin
                  mode_in = M_IDLE;
                  held_in = 8'h00;
                  len_in  = '0;
                  cnt_in  = '0;
                  ovf_in  = 1'b0;
               end
            end
         end
         default: fst_in = F_ACCEPT;
      endcase

      // lexeme append: a new token switches to the other text bank
      idx       = new_tok ? '0 : len_ff;
      bank_n    = new_tok ? ~bank_ff : bank_ff;
      kw_base   = new_tok ? '1 : kwm_ff;
      ram_wdata = app_c;
      if (new_tok) begin
         bank_in = bank_n;
         len_in  = '0;
         kwm_in  = kw_base;
      end
      if (do_app && idx < LEN_CAP) begin
         ram_we    = 1'b1;
         ram_waddr = {bank_n, idx};
         len_in    = idx + IDX_W'(1);
         for (int k = 0; k < KW_COUNT; k++) begin
            kwm_in[k] = kw_base[k] && (kw_char(k, int'(idx)) == app_c);
         end
      end

      if (done) begin
         fst_in = last_ff ? F_FLUSH : F_MARK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fst_ff  <= F_ACCEPT;
         mode_ff <= M_IDLE;
         held_ff <= 8'h00;
         last_ff <= 1'b0;
         len_ff  <= '0;
         bank_ff <= 1'b0;
         cnt_ff  <= '0;
         ovf_ff  <= 1'b0;
      end else begin
         fst_ff  <= fst_in;
         mode_ff <= mode_in;
         held_ff <= held_in;
         last_ff <= last_in;
         len_ff  <= len_in;
         bank_ff <= bank_in;
         cnt_ff  <= cnt_in;
         ovf_ff  <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      kwm_ff <= kwm_in;
   end

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.q_full)
      else $error("command pushed into a full queue");

   a_accept_drained: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> (status.drained && fst_ff == F_ACCEPT))
      else $error("byte accepted while the back end was busy");

endmodule

>>> src/stt_back.sv
// Emitter back: pops token commands, reads lexeme text from the RAM and
// drives result rows, holding one row back to mark the last of each item.
// Depends on stt_pkg.
module stt_back import stt_pkg::*; #(
   parameter int LEXEME_BYTES = LEXEME_BYTES_DEF,
   localparam int IDX_W = $clog2(LEXEME_BYTES)
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           q_empty,
   input  cmd_type        q_head,
   output logic           q_pop,
   output logic           rd_en,
   output logic [IDX_W:0] rd_addr,
   input  logic [7:0]     rd_data,
   output logic           idle,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output logic [5:0]     rsp_token_type,
   output logic [4:0]     rsp_lexeme_length,
   output logic [4:0]     rsp_char_position,
   output logic [7:0]     rsp_lexeme_char,
   output logic           rsp_token_end,
   output logic           rsp_run_last
);

   back_state_type       bst_ff, bst_in;
   logic [5:0]           tok_ff, tok_in;
   logic [LEN_MAX_W-1:0] tlen_ff, tlen_in, tpos_ff, tpos_in;
   logic                 tbank_ff, tbank_in;
   row_type              hold_ff, out_ff, row;
   logic                 hold_vld_ff, out_vld_ff, out_last_ff;
   logic                 out_free, can_emit, move, move_last, load, row_end;

   assign out_free = !out_vld_ff || !rsp_stall;
   assign can_emit = !hold_vld_ff || out_free;
   assign row_end  = (tpos_ff == tlen_ff - LEN_MAX_W'(1));
   assign rd_addr  = {tbank_ff, tpos_ff[IDX_W-1:0]};
   assign idle     = (bst_ff == B_IDLE);

   always_comb begin
      bst_in    = bst_ff;
      tok_in    = tok_ff;
      tlen_in   = tlen_ff;
      tpos_in   = tpos_ff;
      tbank_in  = tbank_ff;
      q_pop     = 1'b0;
      rd_en     = 1'b0;
      move      = 1'b0;
      move_last = 1'b0;
      load      = 1'b0;
      row.tok   = q_head.tok;
      row.len   = 5'd0;
      row.pos   = 5'd0;
      row.ch    = 8'h00;
      row.tend  = 1'b1;
      case (bst_ff)
         B_IDLE: begin
            if (!q_empty) begin
               case (q_head.kind)
                  CMD_MARK: begin
                     if (!hold_vld_ff) begin
                        q_pop = 1'b1;
                     end else if (out_free) begin
                        q_pop     = 1'b1;
                        move      = 1'b1;
                        move_last = 1'b1;
                     end
                  end
                  CMD_PLAIN: begin
                     if (can_emit) begin
                        q_pop = 1'b1;
                        move  = hold_vld_ff;
                        load  = 1'b1;
                     end
                  end
                  CMD_TEXT: begin
                     q_pop    = 1'b1;
                     tok_in   = q_head.tok;
                     tlen_in  = q_head.len;
                     tpos_in  = '0;
                     tbank_in = q_head.bank;
                     bst_in   = B_READ;
                  end
                  default: q_pop = 1'b1;
               endcase
            end
         end
         B_READ: begin
            rd_en  = 1'b1;
            bst_in = B_ROW;
         end
         B_ROW: begin
            row.tok  = tok_ff;
            row.len  = tlen_ff[4:0];
            row.pos  = tpos_ff[4:0];
            row.ch   = rd_data;
            row.tend = row_end;
            if (can_emit) begin
               move = hold_vld_ff;
               load = 1'b1;
               if (row_end) begin
                  bst_in = B_IDLE;
               end else begin
                  tpos_in = tpos_ff + LEN_MAX_W'(1);
                  bst_in  = B_READ;
               end
            end
         end
         default: bst_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bst_ff      <= B_IDLE;
         hold_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         bst_ff <= bst_in;
         if (load) begin
            hold_vld_ff <= 1'b1;
         end else if (move) begin
            hold_vld_ff <= 1'b0;
         end
         if (move) begin
            out_vld_ff <= 1'b1;
         end else if (out_free) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      tok_ff   <= tok_in;
      tlen_ff  <= tlen_in;
      tpos_ff  <= tpos_in;
      tbank_ff <= tbank_in;
      if (load) begin
         hold_ff <= row;
      end
      if (move) begin
         out_ff      <= hold_ff;
         out_last_ff <= move_last;
      end
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_token_type    = out_ff.tok;
   assign rsp_lexeme_length = out_ff.len;
   assign rsp_char_position = out_ff.pos;
   assign rsp_lexeme_char   = out_ff.ch;
   assign rsp_token_end     = out_ff.tend;
   assign rsp_run_last      = out_last_ff;

   a_last_ends_token: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && out_last_ff) |-> out_ff.tend)
      else $error("item closed in the middle of a token");

   a_end_position: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && out_ff.tend && out_ff.len != 5'd0) |->
         (out_ff.pos == out_ff.len - 5'd1))
      else $error("token end at wrong character position");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("pop from an empty queue");

endmodule

>>> src/source_text_tokenizer.sv
// Top level of the source text tokenizer: configuration register, scanner
// front, command queue, lexeme RAM and emitter back. Depends on stt_pkg.
//
// Usage:
//   req_*  carries one source byte per item (req_char_value) and marks the
//          last byte of a source (req_end_of_source). The block raises
//          req_stall while earlier work is still in flight.
//   rsp_*  carries one result row per item: token type, stored text length,
//          character position, the character, token end and the last-row
//          mark for the source byte that caused it. Hold rsp_stall high to
//          pause; the current row and everything behind it hold.
//   csr_*  writes token_limit (tokens per source including EOF); write it
//          only while the block is idle. csr_ready is always high.
// Flow: the front takes a byte, runs its scan steps (a held look-ahead byte
//   that is judged again takes another step, a digit after a dot another)
//   and queues the end-of-item mark. Each text character then passes the
//   back as a RAM read, then a row. The next byte is taken once the back
//   has drained.
// Reset: synchronous, active high; token_limit returns to 4096 and the
//   scanner starts a fresh source. The lexeme RAM needs no clearing.
module source_text_tokenizer import stt_pkg::*; #(
   parameter int LEXEME_BYTES = LEXEME_BYTES_DEF,
   parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
   localparam int IDX_W = $clog2(LEXEME_BYTES)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_char_value,
   input  logic               req_end_of_source,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [5:0]         rsp_token_type,
   output logic [4:0]         rsp_lexeme_length,
   output logic [4:0]         rsp_char_position,
   output logic [7:0]         rsp_lexeme_char,
   output logic               rsp_token_end,
   output logic               rsp_run_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [LIMIT_W-1:0] csr_data
);

   logic [LIMIT_W-1:0] limit_ff;
   stt_status_type     status;
   logic               push, pop, q_empty, q_full, back_idle;
   cmd_type            push_cmd, q_head;
   logic               ram_we, rd_en;
   logic [IDX_W:0]     ram_waddr, rd_addr;
   logic [7:0]         ram_wdata, rd_data;

   // register always writable; user writes only while idle (not enforced)
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= TOKEN_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_data;
      end
   end

   // front may take a new byte only when the back has nothing left to read
   assign status.q_full  = q_full;
   assign status.drained = q_empty && back_idle;

   stt_front #(.LEXEME_BYTES(LEXEME_BYTES)) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_char_value    (req_char_value),
      .req_end_of_source (req_end_of_source),
      .token_limit       (limit_ff),
      .status            (status),
      .push              (push),
      .cmd               (push_cmd),
      .ram_we            (ram_we),
      .ram_waddr         (ram_waddr),
      .ram_wdata         (ram_wdata)
   );

   stt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (q_head),
      .empty    (q_empty),
      .full     (q_full)
   );

   // two text banks: one being emitted, one being filled
   stt_ram #(.WIDTH(8), .DEPTH(2 ** (IDX_W + 1))) u_lexeme_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (rd_en),
      .raddr (rd_addr),
      .rdata (rd_data)
   );

   stt_back #(.LEXEME_BYTES(LEXEME_BYTES)) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_head            (q_head),
      .q_pop             (pop),
      .rd_en             (rd_en),
      .rd_addr           (rd_addr),
      .rd_data           (rd_data),
      .idle              (back_idle),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_token_type    (rsp_token_type),
      .rsp_lexeme_length (rsp_lexeme_length),
      .rsp_char_position (rsp_char_position),
      .rsp_lexeme_char   (rsp_lexeme_char),
      .rsp_token_end     (rsp_token_end),
      .rsp_run_last      (rsp_run_last)
   );

endmodule

>>> dv/stt_checker.sv
// Checker for the source text tokenizer: watches the three channels, predicts
// the rows that each accepted byte causes and compares them. Depends on stt_pkg.
`timescale 1ns / 100ps
module stt_checker import stt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_char_value,
   input  logic        req_end_of_source,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [5:0]  rsp_token_type,
   input  logic [4:0]  rsp_lexeme_length,
   input  logic [4:0]  rsp_char_position,
   input  logic [7:0]  rsp_lexeme_char,
   input  logic        rsp_token_end,
   input  logic        rsp_run_last,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [15:0] csr_data,
   output int          fail_count,
   output int          pending
);

   typedef struct packed {
      logic [5:0] tok;
      logic [4:0] len;
      logic [4:0] pos;
      logic [7:0] ch;
      logic       tend;
      logic       last;
   } token_row_type;

   localparam int KEEP_MAX = 31;
   string keywords [17] = '{"var", "ret", "out", "rep", "fun", "if", "else", "end",
      "keyPressed", "keyDown", "add", "stop", "str", "and", "or", "not", "qbit"};

   token_row_type expected_rows [$];
   logic [15:0]   limit;
   scan_mode_type mode;
   logic [7:0]    held;
   logic [7:0]    lex [32];
   int            slen;
   int            tokens_seen;
   bit            dropped;

   assign pending = expected_rows.size();

   function automatic void add_row(logic [5:0] t, int len, int pos, logic [7:0] c, bit e);
      token_row_type r;
      r.tok = t; r.len = len[4:0]; r.pos = pos[4:0]; r.ch = c; r.tend = e; r.last = 1'b0;
      expected_rows.push_back(r);
   endfunction

   function automatic void plain(logic [5:0] t);
      add_row(t, 0, 0, 8'h00, 1'b1);
   endfunction

   function automatic void text(logic [5:0] t);
      if (slen == 0) begin
         plain(t);
         return;
      end
      for (int i = 0; i < slen; i++) add_row(t, slen, i, lex[i], i + 1 == slen);
   endfunction

   function automatic void keep(logic [7:0] c);
      if (slen < KEEP_MAX) begin
         lex[slen] = c;
         slen++;
      end
   endfunction

   function automatic bit digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic bit lookahead_char(logic [7:0] c);
      return c == CH_PLUS || c == CH_MINUS || c == CH_EQ || c == CH_BANG || c == CH_GT ||
             c == CH_LT || c == CH_STAR || c == CH_SLASH || c == CH_DOT;
   endfunction

   function automatic logic [5:0] punct_code(logic [7:0] c);
      case (c)
         CH_LBRACE: return TK_LBRACE;
         CH_RBRACE: return TK_RBRACE;
         CH_LPAREN: return TK_LPAREN;
         CH_RPAREN: return TK_RPAREN;
         CH_LBRACK: return TK_LBRACK;
         CH_RBRACK: return TK_RBRACK;
         CH_COMMA:  return TK_COMMA;
         CH_EQ:     return TK_ASSIGN;
         CH_GT:     return TK_GT;
         CH_LT:     return TK_LT;
         CH_PLUS:   return TK_PLUS;
         CH_MINUS:  return TK_MINUS;
         CH_STAR:   return TK_STAR;
         CH_SLASH:  return TK_SLASH;
         CH_PCT:    return TK_PERCENT;
         CH_DOT:    return TK_DOT;
         default:   return TK_UNKNOWN;
      endcase
   endfunction

   function automatic logic [5:0] word_code();
      bit same;
      for (int k = 0; k < 17; k++) begin
         same = keywords[k].len() == slen;
         for (int i = 0; same && i < slen; i++) same = keywords[k][i] == lex[i];
         if (same) return TK_KEYWORD0 + 6'(k);
      end
      return TK_IDENT;
   endfunction

   // take a token slot, or report overflow and drop the rest of the source
   function automatic bit claim();
      if (dropped) return 1'b0;
      if (tokens_seen + 1 >= int'(limit)) begin
         plain(TK_OVERFLOW);
         dropped = 1'b1;
         mode = M_IDLE;
         return 1'b0;
      end
      tokens_seen++;
      return 1'b1;
   endfunction

   // judge held byte h against look-ahead c; 1 when c is used up
   function automatic bit settle(logic [7:0] h, logic [7:0] c);
      if (h == CH_SLASH && c == CH_SLASH) begin
         mode = M_COMMENT;
         return 1'b1;
      end
      if (!claim()) return 1'b1;
      if (h == CH_DOT && digit(c)) begin
         slen = 0;
         keep(CH_DOT);
         keep(c);
         mode = M_FRACTION;
         return 1'b1;
      end
      mode = M_IDLE;
      if (h == CH_PLUS && c == CH_PLUS) begin
         plain(TK_INC);
         return 1'b1;
      end
      if (h == CH_MINUS && c == CH_MINUS) begin
         plain(TK_DEC);
         return 1'b1;
      end
      if (c == CH_EQ) begin
         case (h)
            CH_EQ:    begin plain(TK_EQ_EQ);  return 1'b1; end
            CH_BANG:  begin plain(TK_NOT_EQ); return 1'b1; end
            CH_GT:    begin plain(TK_GT_EQ);  return 1'b1; end
            CH_LT:    begin plain(TK_LT_EQ);  return 1'b1; end
            CH_PLUS:  begin plain(TK_ADD_EQ); return 1'b1; end
            CH_MINUS: begin plain(TK_SUB_EQ); return 1'b1; end
            CH_STAR:  begin plain(TK_MUL_EQ); return 1'b1; end
            CH_SLASH: begin plain(TK_DIV_EQ); return 1'b1; end
            default: ;
         endcase
      end
      plain(punct_code(h));
      return 1'b0;
   endfunction

   function automatic void begin_token(logic [7:0] c);
      if (c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D)) return;
      if (lookahead_char(c)) begin
         held = c;
         mode = M_HOLD;
         return;
      end
      if (!claim()) return;
      slen = 0;
      if (c == CH_QUOTE) mode = M_STRING;
      else if (digit(c)) begin
         keep(c);
         mode = M_NUMBER;
      end else if (alpha(c)) begin
         keep(c);
         mode = M_IDENT;
      end else plain(punct_code(c));
   endfunction

   function automatic void scan(logic [7:0] c);
      forever begin
         if (dropped) return;
         case (mode)
            M_IDLE: begin
               begin_token(c);
               return;
            end
            M_HOLD: begin
               if (settle(held, c)) return;
               mode = M_IDLE;
            end
            M_IDENT: begin
               if (alpha(c) || digit(c)) begin
                  keep(c);
                  return;
               end
               text(word_code());
               mode = M_IDLE;
            end
            M_NUMBER: begin
               if (digit(c)) begin
                  keep(c);
                  return;
               end
               if (c == CH_DOT) begin
                  mode = M_NUMDOT;
                  return;
               end
               text(TK_NUMBER);
               mode = M_IDLE;
            end
            M_NUMDOT: begin
               if (digit(c)) begin
                  keep(CH_DOT);
                  keep(c);
                  mode = M_FRACTION;
                  return;
               end
               text(TK_NUMBER);
               held = CH_DOT;
               mode = M_HOLD;
            end
            M_FRACTION: begin
               if (digit(c)) begin
                  keep(c);
                  return;
               end
               text(TK_NUMBER);
               mode = M_IDLE;
            end
            M_STRING: begin
               if (c == CH_QUOTE) begin
                  text(TK_STRING);
                  mode = M_IDLE;
               end else keep(c);
               return;
            end
            default: begin
               if (c == CH_NL) mode = M_IDLE;
               return;
            end
         endcase
      end
   endfunction

   function automatic void finish_source();
      case (mode)
         M_IDENT: text(word_code());
         M_NUMBER, M_FRACTION: text(TK_NUMBER);
         M_NUMDOT: begin
            text(TK_NUMBER);
            if (claim()) plain(TK_DOT);
         end
         M_HOLD: if (claim()) plain(punct_code(held));
         M_STRING: text(TK_STRING);
         default: ;
      endcase
      if (!dropped) plain(TK_EOF);
   endfunction

   function automatic void clear_source();
      mode = M_IDLE;
      held = 8'h00;
      slen = 0;
      tokens_seen = 0;
      dropped = 1'b0;
   endfunction

   function automatic void take_byte(logic [7:0] c, bit eos);
      int before_n;
      before_n = expected_rows.size();
      if (!dropped) scan(c);
      if (eos) begin
         if (!dropped) finish_source();
         clear_source();
      end
      if (expected_rows.size() > before_n) expected_rows[expected_rows.size() - 1].last = 1'b1;
   endfunction

   task automatic report(string what, int got, int want);
      $display("%0t mismatch %s: got %0d, want %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      token_row_type w;
      if (reset) begin
         limit = TOKEN_LIMIT_RESET;
         clear_source();
         expected_rows.delete();
      end else begin
         if (csr_valid && csr_ready) limit = csr_data;
         if (rsp_valid && !rsp_stall) begin
            if (expected_rows.size() == 0) begin
               report("unexpected row, type", rsp_token_type, -1);
            end else begin
               w = expected_rows.pop_front();
               if (rsp_token_type !== w.tok) report("token_type", rsp_token_type, w.tok);
               if (rsp_lexeme_length !== w.len)
                  report("lexeme_length", rsp_lexeme_length, w.len);
               if (rsp_char_position !== w.pos)
                  report("char_position", rsp_char_position, w.pos);
               if (rsp_lexeme_char !== w.ch) report("lexeme_char", rsp_lexeme_char, w.ch);
               if (rsp_token_end !== w.tend) report("token_end", rsp_token_end, w.tend);
               if (rsp_run_last !== w.last) report("run_last", rsp_run_last, w.last);
            end
         end
         if (req_valid && !req_stall) take_byte(req_char_value, req_end_of_source);
      end
   end

endmodule

>>> dv/tb_source_text_tokenizer.sv
// Testbench top for the source text tokenizer: drives source bytes, token
// limits and back-pressure; checking lives in stt_checker. Depends on stt_pkg.
`timescale 1ns / 100ps
module tb_source_text_tokenizer;
   import stt_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_char_value;
   logic        req_end_of_source;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [5:0]  rsp_token_type;
   logic [4:0]  rsp_lexeme_length;
   logic [4:0]  rsp_char_position;
   logic [7:0]  rsp_lexeme_char;
   logic        rsp_token_end;
   logic        rsp_run_last;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_data;
   int          fail_count;
   int          pending;

   // idle odds in percent for the sender and the receiver
   int          send_gap_pct;
   int          stall_pct;
   int          bytes_sent;
   logic [7:0]  src [$];

   // drain budget: room for a full 31-char token to be emitted, plus slack
   localparam int DRAIN_CYCLES = 120;

   string keywords [17] = '{"var", "ret", "out", "rep", "fun", "if", "else", "end",
      "keyPressed", "keyDown", "add", "stop", "str", "and", "or", "not", "qbit"};
   string pairs [10] = '{"++", "--", "==", "!=", ">=", "<=", "+=", "-=", "*=", "/="};
   string puncts = "{}()[],=><+-*/%.";

   source_text_tokenizer dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_char_value(req_char_value), .req_end_of_source(req_end_of_source),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_token_type(rsp_token_type), .rsp_lexeme_length(rsp_lexeme_length),
      .rsp_char_position(rsp_char_position), .rsp_lexeme_char(rsp_lexeme_char),
      .rsp_token_end(rsp_token_end), .rsp_run_last(rsp_run_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   stt_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_char_value(req_char_value), .req_end_of_source(req_end_of_source),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_token_type(rsp_token_type), .rsp_lexeme_length(rsp_lexeme_length),
      .rsp_char_position(rsp_char_position), .rsp_lexeme_char(rsp_lexeme_char),
      .rsp_token_end(rsp_token_end), .rsp_run_last(rsp_run_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // receiver back-pressure: redraw once per cycle at the falling edge
   always @(negedge clock) rsp_stall <= $urandom_range(99) < stall_pct;

   // hard stop in case the block hangs
   initial begin
      #10ms;
      $display("tb_source_text_tokenizer: errors");
      $finish;
   end

   // send one byte: optional idle gap, then hold the item until it is taken
   task automatic put_byte(logic [7:0] c, bit eos);
      while ($urandom_range(99) < send_gap_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
         req_char_value <= 8'($urandom_range(255));
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_char_value <= c;
      req_end_of_source <= eos;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   // push the queued source out, with end of source on its last byte
   task automatic send_source();
      for (int i = 0; i < src.size(); i++) put_byte(src[i], i == src.size() - 1);
      src.delete();
   endtask

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) src.push_back(s[i]);
   endtask

   // wait for every expected row, then let in-flight bytes without rows settle
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_limit(logic [15:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic add_digits(int n);
      repeat (n) src.push_back(8'($urandom_range("0", "9")));
   endtask

   task automatic add_word(int n);
      logic [7:0] c;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(2))
            0: c = 8'($urandom_range("a", "z"));
            1: c = 8'($urandom_range("A", "Z"));
            default: c = (i == 0) ? "x" : 8'($urandom_range("0", "9"));
         endcase
         src.push_back(c);
      end
   endtask

   // one random lexical piece; mostly well formed, some noise
   task automatic add_piece();
      logic [7:0] c;
      case ($urandom_range(13))
         0, 1: add_word(($urandom_range(9) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 6));
         2: add_text(keywords[$urandom_range(16)]);
         3: begin
            add_digits($urandom_range(1, 4));
            case ($urandom_range(2))
               0: begin src.push_back(CH_DOT); add_digits($urandom_range(1, 3)); end
               1: src.push_back(CH_DOT);
               default: ;
            endcase
         end
         4: begin src.push_back(CH_DOT); add_digits($urandom_range(1, 3)); end
         5: begin
            src.push_back(CH_QUOTE);
            repeat (($urandom_range(7) == 0) ? $urandom_range(25, 36) : $urandom_range(0, 5)) begin
               do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE);
               src.push_back(c);
            end
            if ($urandom_range(9) != 0) src.push_back(CH_QUOTE);
         end
         6, 7: add_text(pairs[$urandom_range(9)]);
         8: src.push_back(puncts[$urandom_range(15)]);
         9: begin
            add_text("//");
            repeat ($urandom_range(0, 6)) begin
               do c = 8'($urandom_range(1, 255)); while (c == CH_NL);
               src.push_back(c);
            end
            if ($urandom_range(4) != 0) src.push_back(CH_NL);
         end
         10: src.push_back(8'($urandom_range(9, 13)));
         11: src.push_back(CH_BANG);
         default: src.push_back(8'($urandom_range(1, 255)));
      endcase
      if ($urandom_range(2) == 0) src.push_back(CH_SPACE);
   endtask

   initial begin
      logic [15:0] limits [6];
      reset = 1'b1;
      req_valid = 1'b0;
      req_char_value = 8'h00;
      req_end_of_source = 1'b0;
      csr_valid = 1'b0;
      csr_data = 16'h0000;
      send_gap_pct = 0;
      stall_pct = 0;
      bytes_sent = 0;
      limits = '{16'd4096, 16'd2, 16'd65535, 16'd3, 16'd9, 16'd6};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: keywords, long text, numbers, dots, lone bang, comments
      add_text("keyPressed keyDown+=x9 12.5 3.a .7 !x /=//c\n");
      send_source();
      add_text("\"abcdefghijklmnopqrstuvwxyz0123456789\" ");
      src.push_back(8'hFF);
      src.push_back(8'h80);
      send_source();
      add_text("4.");                             // end on dot after digits
      send_source();
      add_text("\"open");                         // unterminated string
      send_source();
      add_text("<");                              // end on a held byte
      send_source();
      drain();
      set_limit(16'd2);                           // overflow on the second token
      add_text("ab cd");
      send_source();
      drain();
      set_limit(16'd3);
      add_text("+ - ( )");                        // overflow on a plain punctuation byte
      send_source();
      drain();

      // random sources, switching limits and back-pressure every phase
      for (int ph = 0; bytes_sent < 440; ph++) begin
         case (ph % 4)
            0: begin send_gap_pct = 0;  stall_pct = 0;  end
            1: begin send_gap_pct = 61; stall_pct = 0;  end
            2: begin send_gap_pct = 0;  stall_pct = 61; end
            default: begin send_gap_pct = 14; stall_pct = 14; end
         endcase
         drain();
         set_limit((ph % 7 == 6) ? 16'($urandom_range(2, 20)) : limits[ph % 6]);
         repeat (4) begin
            repeat ($urandom_range(1, 10)) add_piece();
            send_source();
         end
      end

      drain();
      if (fail_count == 0 && pending == 0) begin
         $display("tb_source_text_tokenizer: clean");
      end else begin
         $display("tb_source_text_tokenizer: errors");
      end
      $finish;
   end

endmodule
